// ----- sv/wnwa_pkg.sv -----
// ----------------------------------------------------------------------------
// wnwa_pkg
// Types and constants shared by the weighted wall normal average block.
// ----------------------------------------------------------------------------
package wnwa_pkg;

    localparam int FRAC_BITS = 14;
    localparam int SUM_W     = 48;
    localparam int PROD_W    = 46;
    localparam int DNUM_W    = 46;
    localparam int DDEN_W    = 31;
    localparam int WGT_W     = 29;
    localparam int MAG_IN_W  = 30;
    localparam int SQ_W      = 60;
    localparam int SS_W      = 62;
    localparam int RT_W      = 64;
    localparam int CNT_W     = 6;

    localparam logic [CNT_W-1:0] WDIV_STEPS = CNT_W'(WGT_W - 1);
    localparam logic [CNT_W-1:0] QDIV_STEPS = CNT_W'(DNUM_W - 1);
    localparam logic [CNT_W-1:0] ROOT_STEPS = CNT_W'(31);

    localparam logic [1:0] COMP_X = 2'd0;
    localparam logic [1:0] COMP_Z = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DISPATCH,
        S_WDIV,
        S_MUL,
        S_ACC,
        S_END,
        S_ABS,
        S_SHIFT,
        S_SQ,
        S_SQACC,
        S_RTINIT,
        S_SQRT,
        S_QLOAD,
        S_QDIV,
        S_QSTORE,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic       load_in;
        logic       div_start_w;
        logic       div_start_q;
        logic       div_step;
        logic       mul;
        logic       acc;
        logic       mag_abs;
        logic       shift_r;
        logic       shift_l;
        logic       sq;
        logic       sqacc;
        logic       rt_init;
        logic       rt_step;
        logic       qstore;
        logic       emit;
        logic [1:0] comp;
    } t_cmd;

    typedef struct packed {
        logic fluid;
        logic wall;
        logic last;
        logic wall_seen;
        logic mag_zero;
        logic mag_hi;
        logic mag_lo;
        logic out_free;
    } t_status;

endpackage

// ----- sv/wnwa_if.sv -----
// ----------------------------------------------------------------------------
// wnwa_in_if / wnwa_out_if
// Valid/ready channels for link items and averaged normal results.
// ----------------------------------------------------------------------------
interface wnwa_in_if;
    logic        valid;
    logic        ready;
    logic        site_fluid;
    logic        link_is_wall;
    logic [15:0] link_distance;
    logic signed [15:0] normal_x;
    logic signed [15:0] normal_y;
    logic signed [15:0] normal_z;
    logic        last_link;

    modport source (output valid, site_fluid, link_is_wall, link_distance,
                    normal_x, normal_y, normal_z, last_link, input ready);
    modport sink   (input valid, site_fluid, link_is_wall, link_distance,
                    normal_x, normal_y, normal_z, last_link, output ready);
endinterface

interface wnwa_out_if;
    logic        valid;
    logic        ready;
    logic        normal_available;
    logic signed [15:0] out_normal_x;
    logic signed [15:0] out_normal_y;
    logic signed [15:0] out_normal_z;

    modport source (output valid, normal_available, out_normal_x, out_normal_y,
                    out_normal_z, input ready);
    modport sink   (input valid, normal_available, out_normal_x, out_normal_y,
                    out_normal_z, output ready);
endinterface

// ----- sv/wnwa_ctrl.sv -----
// ----------------------------------------------------------------------------
// wnwa_ctrl
// Sequencer for link accumulation and unit vector normalization.
// ----------------------------------------------------------------------------
module wnwa_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  wnwa_pkg::t_status i_status,
    output wnwa_pkg::t_cmd    o_cmd
);
    import wnwa_pkg::*;

    t_state           r_state, n_state;
    logic [CNT_W-1:0] r_cnt, n_cnt;
    logic [1:0]       r_comp, n_comp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_comp  <= COMP_X;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_comp  <= n_comp;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        n_comp     = r_comp;
        o_cmd      = '0;
        o_cmd.comp = r_comp;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = i_rst_n;
                if (i_in_valid && i_rst_n) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_DISPATCH;
                end
            end
            S_DISPATCH: begin
                if (i_status.fluid && i_status.wall) begin
                    o_cmd.div_start_w = 1'b1;
                    n_cnt             = WDIV_STEPS;
                    n_state           = S_WDIV;
                end else begin
                    n_state = S_END;
                end
            end
            S_WDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_comp  = COMP_X;
                    n_state = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_ACC;
            end
            S_ACC: begin
                o_cmd.acc = 1'b1;
                if (r_comp == COMP_Z) begin
                    n_state = S_END;
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = S_MUL;
                end
            end
            S_END: begin
                if (!i_status.last) begin
                    n_state = S_IDLE;
                end else if (i_status.fluid && i_status.wall_seen) begin
                    n_state = S_ABS;
                end else begin
                    n_state = S_EMIT;
                end
            end
            S_ABS: begin
                o_cmd.mag_abs = 1'b1;
                n_state       = S_SHIFT;
            end
            S_SHIFT: begin
                priority if (i_status.mag_zero) begin
                    n_state = S_EMIT;
                end else if (i_status.mag_hi) begin
                    o_cmd.shift_r = 1'b1;
                end else if (i_status.mag_lo) begin
                    o_cmd.shift_l = 1'b1;
                end else begin
                    n_comp  = COMP_X;
                    n_state = S_SQ;
                end
            end
            S_SQ: begin
                o_cmd.sq = 1'b1;
                n_state  = S_SQACC;
            end
            S_SQACC: begin
                o_cmd.sqacc = 1'b1;
                if (r_comp == COMP_Z) begin
                    n_state = S_RTINIT;
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = S_SQ;
                end
            end
            S_RTINIT: begin
                o_cmd.rt_init = 1'b1;
                n_cnt         = ROOT_STEPS;
                n_state       = S_SQRT;
            end
            S_SQRT: begin
                o_cmd.rt_step = 1'b1;
                n_cnt         = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_comp  = COMP_X;
                    n_state = S_QLOAD;
                end
            end
            S_QLOAD: begin
                o_cmd.div_start_q = 1'b1;
                n_cnt             = QDIV_STEPS;
                n_state           = S_QDIV;
            end
            S_QDIV: begin
                o_cmd.div_step = 1'b1;
                n_cnt          = r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    n_state = S_QSTORE;
                end
            end
            S_QSTORE: begin
                o_cmd.qstore = 1'b1;
                if (r_comp == COMP_Z) begin
                    n_state = S_EMIT;
                end else begin
                    n_comp  = r_comp + 1'b1;
                    n_state = S_QLOAD;
                end
            end
            S_EMIT: begin
                if (i_status.out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ----- sv/wnwa_datapath.sv -----
// ----------------------------------------------------------------------------
// wnwa_datapath
// Shared divider, multiplier, saturating sums, square root and output register.
// ----------------------------------------------------------------------------
module wnwa_datapath (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  wnwa_pkg::t_cmd     i_cmd,
    output wnwa_pkg::t_status  o_status,
    wnwa_in_if.sink            i_in,
    wnwa_out_if.source         o_out
);
    import wnwa_pkg::*;

    logic               r_fluid, r_wall, r_last;
    logic [15:0]        r_dist;
    logic signed [15:0] r_nrm [3];
    logic [SUM_W-1:0]   r_sum [3];
    logic               r_wall_seen;
    logic signed [PROD_W-1:0] r_prod;
    logic [DNUM_W-1:0]  r_dnum;
    logic [DDEN_W-1:0]  r_drem, r_dden;
    logic [SUM_W-1:0]   r_mag [3];
    logic [2:0]         r_neg;
    logic [SQ_W-1:0]    r_sq;
    logic [SS_W-1:0]    r_ss;
    logic [RT_W-1:0]    r_v, r_root, r_bit;
    logic [15:0]        r_res [3];
    logic               r_ovalid, r_oavail;
    logic [15:0]        r_ox, r_oy, r_oz;

    logic [DDEN_W:0]    div_t;
    logic               div_q;
    logic [SUM_W:0]     acc_s;
    logic [RT_W-1:0]    rt_t;
    logic [SUM_W-1:0]   mag_or;
    logic [15:0]        q_sat;
    logic [DNUM_W-2:0]  q_num;
    logic [15:0]        d_eff;

    assign div_t  = {r_drem, r_dnum[DNUM_W-1]};
    assign div_q  = (div_t >= {1'b0, r_dden});
    assign acc_s  = {r_sum[i_cmd.comp][SUM_W-1], r_sum[i_cmd.comp]}
                  + {{(SUM_W+1-(PROD_W-FRAC_BITS)){r_prod[PROD_W-1]}},
                     r_prod[PROD_W-1:FRAC_BITS]};
    assign rt_t   = r_root + r_bit;
    assign mag_or = r_mag[0] | r_mag[1] | r_mag[2];
    assign d_eff  = (r_dist == 16'd0) ? 16'd1 : r_dist;
    assign q_num  = {1'b0, r_mag[i_cmd.comp][MAG_IN_W-1:0], {FRAC_BITS{1'b0}}}
                  + {{(DNUM_W-1-(DDEN_W-1)){1'b0}}, r_root[DDEN_W-1:1]};

    always_comb begin
        if (r_neg[i_cmd.comp]) begin
            if (r_dnum > DNUM_W'(32768)) q_sat = 16'h8000;
            else q_sat = ~r_dnum[15:0] + 16'd1;
        end else begin
            if (r_dnum > DNUM_W'(32767)) q_sat = 16'h7fff;
            else q_sat = r_dnum[15:0];
        end
    end

    assign o_status.fluid     = r_fluid;
    assign o_status.wall      = r_wall;
    assign o_status.last      = r_last;
    assign o_status.wall_seen = r_wall_seen;
    assign o_status.mag_zero  = (mag_or == '0);
    assign o_status.mag_hi    = (mag_or[SUM_W-1:MAG_IN_W] != '0);
    assign o_status.mag_lo    = (mag_or[SUM_W-1:MAG_IN_W-1] == '0);
    assign o_status.out_free  = !r_ovalid || o_out.ready;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_fluid  <= i_in.site_fluid;
            r_wall   <= i_in.link_is_wall;
            r_last   <= i_in.last_link;
            r_dist   <= i_in.link_distance;
            r_nrm[0] <= i_in.normal_x;
            r_nrm[1] <= i_in.normal_y;
            r_nrm[2] <= i_in.normal_z;
        end
        if (i_cmd.div_start_w) begin
            r_dnum <= {1'b1, {(DNUM_W-1){1'b0}}};
            r_drem <= '0;
            r_dden <= {{(DDEN_W-16){1'b0}}, d_eff};
        end else if (i_cmd.div_start_q) begin
            r_dnum <= {1'b0, q_num};
            r_drem <= '0;
            r_dden <= r_root[DDEN_W-1:0];
        end else if (i_cmd.div_step) begin
            r_dnum <= {r_dnum[DNUM_W-2:0], div_q};
            r_drem <= div_q ? DDEN_W'(div_t - {1'b0, r_dden}) : div_t[DDEN_W-1:0];
        end
        if (i_cmd.mul) begin
            r_prod <= $signed({1'b0, r_dnum[WGT_W-1:0]}) * r_nrm[i_cmd.comp];
        end
        if (i_cmd.mag_abs) begin
            for (int i = 0; i < 3; i++) begin
                r_neg[i] <= r_sum[i][SUM_W-1];
                r_mag[i] <= r_sum[i][SUM_W-1] ? (~r_sum[i] + 1'b1) : r_sum[i];
                r_res[i] <= '0;
            end
            r_ss <= '0;
        end else if (i_cmd.shift_r) begin
            for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
        end else if (i_cmd.shift_l) begin
            for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
        end
        if (i_cmd.sq) begin
            r_sq <= r_mag[i_cmd.comp][MAG_IN_W-1:0] * r_mag[i_cmd.comp][MAG_IN_W-1:0];
        end
        if (i_cmd.sqacc) begin
            r_ss <= r_ss + {{(SS_W-SQ_W){1'b0}}, r_sq};
        end
        if (i_cmd.rt_init) begin
            r_v    <= {{(RT_W-SS_W){1'b0}}, r_ss};
            r_root <= '0;
            r_bit  <= {2'b01, {(RT_W-2){1'b0}}};
        end else if (i_cmd.rt_step) begin
            if (r_v >= rt_t) begin
                r_v    <= r_v - rt_t;
                r_root <= (r_root >> 1) + r_bit;
            end else begin
                r_root <= r_root >> 1;
            end
            r_bit <= r_bit >> 2;
        end
        if (i_cmd.qstore) begin
            r_res[i_cmd.comp] <= q_sat;
        end
        if (i_cmd.emit) begin
            r_oavail <= r_fluid && r_wall_seen;
            r_ox     <= (r_fluid && r_wall_seen) ? r_res[0] : 16'd0;
            r_oy     <= (r_fluid && r_wall_seen) ? r_res[1] : 16'd0;
            r_oz     <= (r_fluid && r_wall_seen) ? r_res[2] : 16'd0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) r_sum[i] <= '0;
            r_wall_seen <= 1'b0;
            r_ovalid    <= 1'b0;
        end else begin
            if (i_cmd.acc) begin
                if (acc_s[SUM_W] != acc_s[SUM_W-1]) begin
                    r_sum[i_cmd.comp] <= acc_s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}}
                                                      : {1'b0, {(SUM_W-1){1'b1}}};
                end else begin
                    r_sum[i_cmd.comp] <= acc_s[SUM_W-1:0];
                end
                r_wall_seen <= 1'b1;
            end
            if (i_cmd.emit) begin
                for (int i = 0; i < 3; i++) r_sum[i] <= '0;
                r_wall_seen <= 1'b0;
                r_ovalid    <= 1'b1;
            end else if (o_out.ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    assign o_out.valid            = r_ovalid;
    assign o_out.normal_available = r_oavail;
    assign o_out.out_normal_x     = r_ox;
    assign o_out.out_normal_y     = r_oy;
    assign o_out.out_normal_z     = r_oz;

endmodule

// ----- sv/wall_normal_weighted_average_core.sv -----
// ----------------------------------------------------------------------------
// wall_normal_weighted_average_core
// Distance weighted average of wall normals over the links of one site.
// ----------------------------------------------------------------------------
// Links arrive one per transfer on i_in; one result per site leaves on o_out
// after the transfer that carries last_link.
// A wall link on a fluid site takes 29 steps of the shared restoring divider
// for the weight, then a multiply and accumulate per axis. A last link adds
// the normalization: shift steps, a square and a sum per axis, 32 square
// root steps and three divider passes, one per axis.
// i_in.ready is high only while the sequencer is idle.
// Results sit in an output register; a stalled receiver holds it, and the
// block keeps taking links until the next result needs that register.
// Synchronous reset clears the sums, the wall flag and the output valid.
// ----------------------------------------------------------------------------
module wall_normal_weighted_average_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    wnwa_in_if.sink    i_in,
    wnwa_out_if.source o_out
);
    import wnwa_pkg::*;

    t_cmd    cmd;
    t_status status;

    wnwa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in.valid),
        .o_in_ready (i_in.ready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    wnwa_datapath u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .o_status (status),
        .i_in     (i_in),
        .o_out    (o_out)
    );

endmodule

// ----- verif/wnwa_tb_pkg.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// wnwa_tb_pkg
// Link stimulus and averaged normal result types for the testbench.
// ----------------------------------------------------------------------------
package wnwa_tb_pkg;

    typedef struct {
        logic               avail;
        logic signed [15:0] x;
        logic signed [15:0] y;
        logic signed [15:0] z;
    } t_unit;

    typedef struct {
        logic               fluid;
        logic               wall;
        logic [15:0]        dlen;
        logic signed [15:0] nx;
        logic signed [15:0] ny;
        logic signed [15:0] nz;
        logic               last;
        logic               has_exp;
        t_unit              exp;
    } t_link;

endpackage

// ----- verif/testbench.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Checks the weighted wall normal average against a built-in predictor.
// Directed links cover distance and normal extremes, zero distance, mixed
// fluid flags, zero-length and large sums; random sites follow, with
// bursty sending and a stalling receiver. Results are compared field by field.
// ----------------------------------------------------------------------------
module testbench;
    import wnwa_pkg::*;
    import wnwa_tb_pkg::*;

    logic i_clk;
    logic i_rst_n;
    int   errors;
    int   sent;
    logic stim_done;

    wnwa_in_if  link_ch ();
    wnwa_out_if unit_ch ();

    wall_normal_weighted_average_core dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (link_ch.sink),
        .o_out   (unit_ch.source)
    );

    longint acc_x, acc_y, acc_z;
    bit     acc_wall;
    t_unit  normals_due[$];
    t_link  links_to_send[$];

    localparam longint ACC_MAX = 64'sh7FFF_FFFF_FFFF;
    localparam longint ACC_MIN = -ACC_MAX - 1;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic longint sat48(longint s, longint a);
        longint r;
        r = s + a;
        if (r > ACC_MAX) return ACC_MAX;
        if (r < ACC_MIN) return ACC_MIN;
        return r;
    endfunction

    function automatic longint weighted(longint w, logic signed [15:0] n);
        longint p;
        p = w * longint'(n);
        return p >>> FRAC_BITS;
    endfunction

    function automatic longint unsigned root64(longint unsigned v);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v) b >>= 2;
        while (b != 0) begin
            if (v >= r + b) begin
                v -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return r;
    endfunction

    function automatic t_unit unit_of(longint sx, longint sy, longint sz);
        t_unit           u;
        longint          s[3];
        longint unsigned mag[3], m, len, q;
        bit              neg[3];
        longint          v;
        s[0] = sx; s[1] = sy; s[2] = sz;
        m = 0;
        for (int i = 0; i < 3; i++) begin
            neg[i] = s[i] < 0;
            mag[i] = neg[i] ? -s[i] : s[i];
            if (mag[i] > m) m = mag[i];
        end
        u.avail = 1'b1;
        u.x = '0; u.y = '0; u.z = '0;
        if (m == 0) return u;
        while (m >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) mag[i] >>= 1;
            m >>= 1;
        end
        while (m < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) mag[i] <<= 1;
            m <<= 1;
        end
        len = root64(mag[0] * mag[0] + mag[1] * mag[1] + mag[2] * mag[2]);
        for (int i = 0; i < 3; i++) begin
            q = ((mag[i] << FRAC_BITS) + (len >> 1)) / len;
            if (neg[i]) begin
                if (q > 32768) q = 32768;
                v = -longint'(q);
            end else begin
                if (q > 32767) q = 32767;
                v = q;
            end
            s[i] = v;
        end
        u.x = s[0][15:0]; u.y = s[1][15:0]; u.z = s[2][15:0];
        return u;
    endfunction

    task automatic predict_link(t_link l);
        longint w;
        longint unsigned d;
        t_unit  u;
        if (l.fluid && l.wall) begin
            d = (l.dlen == 0) ? 1 : l.dlen;
            w = (64'd1 << (2 * FRAC_BITS)) / d;
            acc_x = sat48(acc_x, weighted(w, l.nx));
            acc_y = sat48(acc_y, weighted(w, l.ny));
            acc_z = sat48(acc_z, weighted(w, l.nz));
            acc_wall = 1'b1;
        end
        if (l.last) begin
            if (l.fluid && acc_wall) begin
                u = unit_of(acc_x, acc_y, acc_z);
            end else begin
                u.avail = 1'b0; u.x = '0; u.y = '0; u.z = '0;
            end
            if (l.has_exp) normals_due.push_back(l.exp);
            else normals_due.push_back(u);
            acc_x = 0; acc_y = 0; acc_z = 0;
            acc_wall = 1'b0;
        end
    endtask

    function automatic t_unit un(logic a, logic [15:0] x, logic [15:0] y, logic [15:0] z);
        t_unit u;
        u.avail = a; u.x = x; u.y = y; u.z = z;
        return u;
    endfunction

    function automatic t_link mk(logic f, logic wl, logic [15:0] d, logic [15:0] x,
                                 logic [15:0] y, logic [15:0] z, logic lst);
        t_link l;
        l.fluid = f; l.wall = wl; l.dlen = d;
        l.nx = x; l.ny = y; l.nz = z; l.last = lst;
        l.has_exp = 1'b0;
        return l;
    endfunction

    function automatic t_link mkx(logic f, logic wl, logic [15:0] d, logic [15:0] x,
                                  logic [15:0] y, logic [15:0] z, logic lst, t_unit e);
        t_link l;
        l = mk(f, wl, d, x, y, z, lst);
        l.has_exp = 1'b1;
        l.exp = e;
        return l;
    endfunction

    function automatic t_link rand_link(logic lst, bit wf);
        t_link l;
        int    k;
        l.fluid = ($urandom_range(0, 15) != 0);
        l.wall  = ($urandom_range(0, 2) != 0);
        k = $urandom_range(0, 9);
        l.dlen = (k == 0) ? 16'($urandom_range(0, 3)) :
                 (k == 1) ? 16'hFFFF - 16'($urandom_range(0, 3)) :
                 (k < 6)  ? 16'($urandom_range(1024, 24576)) : 16'($urandom);
        if (wf) begin
            l.nx = 16'($urandom_range(0, 32767)) - 16'sd16384;
            l.ny = 16'($urandom_range(0, 32767)) - 16'sd16384;
            l.nz = 16'($urandom_range(0, 32767)) - 16'sd16384;
        end else begin
            l.nx = 16'($urandom); l.ny = 16'($urandom); l.nz = 16'($urandom);
        end
        l.last = lst;
        l.has_exp = 1'b0;
        return l;
    endfunction

    // sender: bursts and gaps, drive on the falling edge
    initial begin
        t_link l;
        int    burst;
        int    nlinks;
        t_link tbl[$];
        i_rst_n = 1'b0;
        link_ch.valid = 1'b0;
        link_ch.site_fluid = 1'b0; link_ch.link_is_wall = 1'b0;
        link_ch.link_distance = '0; link_ch.normal_x = '0;
        link_ch.normal_y = '0; link_ch.normal_z = '0; link_ch.last_link = 1'b0;
        acc_x = 0; acc_y = 0; acc_z = 0; acc_wall = 1'b0;
        stim_done = 1'b0;
        sent = 0;
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // directed table: extremes, zero distance, mixed fluid, empty sites
        tbl.push_back(mkx(1'b1, 1'b1, 16'h4000, 16'h4000, 16'h0000, 16'h0000, 1'b1,
                          un(1'b1, 16'h4000, 16'h0000, 16'h0000)));
        tbl.push_back(mkx(1'b1, 1'b1, 16'h0000, 16'h0000, 16'h4000, 16'h0000, 1'b1,
                          un(1'b1, 16'h0000, 16'h4000, 16'h0000)));
        tbl.push_back(mkx(1'b1, 1'b1, 16'hFFFF, 16'h0000, 16'h0000, 16'h8000, 1'b1,
                          un(1'b1, 16'h0000, 16'h0000, 16'hC000)));
        tbl.push_back(mkx(1'b1, 1'b0, 16'h4000, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b1,
                          un(1'b0, 16'h0000, 16'h0000, 16'h0000)));
        tbl.push_back(mkx(1'b0, 1'b1, 16'h4000, 16'h4000, 16'h0000, 16'h0000, 1'b1,
                          un(1'b0, 16'h0000, 16'h0000, 16'h0000)));
        tbl.push_back(mkx(1'b1, 1'b1, 16'h4000, 16'h0000, 16'h0000, 16'h0000, 1'b1,
                          un(1'b1, 16'h0000, 16'h0000, 16'h0000)));
        tbl.push_back(mk(1'b1, 1'b1, 16'h4000, 16'h4000, 16'h0000, 16'h0000, 1'b0));
        tbl.push_back(mkx(1'b1, 1'b1, 16'h4000, 16'hC000, 16'h0000, 16'h0000, 1'b1,
                          un(1'b1, 16'h0000, 16'h0000, 16'h0000)));
        tbl.push_back(mk(1'b0, 1'b1, 16'h0001, 16'h7FFF, 16'h7FFF, 16'h7FFF, 1'b0));
        tbl.push_back(mk(1'b1, 1'b1, 16'h2000, 16'h1234, 16'hEDCB, 16'h0F0F, 1'b0));
        tbl.push_back(mkx(1'b0, 1'b0, 16'h5555, 16'hAAAA, 16'h5555, 16'hAAAA, 1'b1,
                          un(1'b0, 16'h0000, 16'h0000, 16'h0000)));
        tbl.push_back(mk(1'b1, 1'b1, 16'h0001, 16'h8000, 16'h7FFF, 16'h0001, 1'b0));
        tbl.push_back(mk(1'b1, 1'b1, 16'hAAAA, 16'h0001, 16'hFFFF, 16'h7FFF, 1'b1));
        for (int i = 0; i < 10; i++)
            tbl.push_back(mk(1'b1, 1'b1, 16'h0000, 16'h7FFF, 16'h8000, 16'h7FFF, i == 9));
        nlinks = 0;
        foreach (tbl[i]) links_to_send.push_back(tbl[i]);
        while (sent < 1350) begin
            nlinks = $urandom_range(1, 30);
            for (int i = 0; i < nlinks; i++)
                links_to_send.push_back(rand_link(i == nlinks - 1,
                                                  $urandom_range(0, 9) != 0));
            sent += nlinks;
        end
        while (links_to_send.size() > 0) begin
            burst = $urandom_range(1, 12);
            while (burst > 0 && links_to_send.size() > 0) begin
                l = links_to_send.pop_front();
                link_ch.valid <= 1'b1;
                link_ch.site_fluid <= l.fluid; link_ch.link_is_wall <= l.wall;
                link_ch.link_distance <= l.dlen; link_ch.normal_x <= l.nx;
                link_ch.normal_y <= l.ny; link_ch.normal_z <= l.nz;
                link_ch.last_link <= l.last;
                @(posedge i_clk);
                while (!link_ch.ready) @(posedge i_clk);
                predict_link(l);
                burst--;
                @(negedge i_clk);
            end
            if ($urandom_range(0, 3) != 0) begin
                link_ch.valid <= 1'b0;
                repeat ($urandom_range(1, 60)) @(negedge i_clk);
            end
        end
        link_ch.valid <= 1'b0;
        stim_done = 1'b1;
    end

    // receiver stall pattern, driven on the falling edge
    initial begin
        int ph;
        unit_ch.ready = 1'b0;
        ph = 0;
        forever begin
            @(negedge i_clk);
            ph++;
            if (ph[9]) unit_ch.ready <= 1'b1;
            else unit_ch.ready <= ($urandom_range(0, 3) != 0) && (ph[5:3] != 3'd5);
        end
    end

    // result check
    initial begin
        t_unit e;
        errors = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && unit_ch.valid && unit_ch.ready) begin
                if (normals_due.size() == 0) begin
                    $display("%0t: unexpected result avail=%0b x=%0d y=%0d z=%0d", $time,
                             unit_ch.normal_available, unit_ch.out_normal_x,
                             unit_ch.out_normal_y, unit_ch.out_normal_z);
                    errors++;
                end else begin
                    e = normals_due.pop_front();
                    if (unit_ch.normal_available !== e.avail) begin
                        $display("%0t: avail exp %0b got %0b", $time, e.avail,
                                 unit_ch.normal_available);
                        errors++;
                    end
                    if (unit_ch.out_normal_x !== e.x) begin
                        $display("%0t: x exp %0d got %0d", $time, e.x, unit_ch.out_normal_x);
                        errors++;
                    end
                    if (unit_ch.out_normal_y !== e.y) begin
                        $display("%0t: y exp %0d got %0d", $time, e.y, unit_ch.out_normal_y);
                        errors++;
                    end
                    if (unit_ch.out_normal_z !== e.z) begin
                        $display("%0t: z exp %0d got %0d", $time, e.z, unit_ch.out_normal_z);
                        errors++;
                    end
                end
            end
        end
    end

    // end of run
    initial begin
        @(posedge i_clk);
        wait (stim_done === 1'b1);
        wait (normals_due.size() == 0);
        repeat (400) @(posedge i_clk);
        if (errors == 0 && normals_due.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule

// ----- wall_normal_weighted_average_core.f -----
sv/wnwa_pkg.sv
sv/wnwa_if.sv
sv/wnwa_ctrl.sv
sv/wnwa_datapath.sv
sv/wall_normal_weighted_average_core.sv
verif/wnwa_tb_pkg.sv
verif/testbench.sv
